[hdl/vqdm_pkg.sv]
// Package for the virtqueue descriptor manager.
// Holds the item, result, memory word and request types and the flag constants.
// No dependencies.
package vqdm_pkg;

	typedef logic [7:0] idx_t;

	localparam logic [1:0] FLAG_NEXT  = 2'b01;
	localparam logic [1:0] FLAG_WRITE = 2'b10;

	typedef enum logic [1:0] {
		OP_INIT     = 2'd0,
		OP_SUBMIT   = 2'd1,
		OP_COMPLETE = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SUB,
		ST_CPL
	} state_t;

	typedef struct packed {
		logic [1:0] operation;
		logic       has_data;
		logic       is_write;
		logic       notify_suppressed;
		logic [7:0] used_id;
	} cmd_t;

	typedef struct packed {
		logic       status;
		logic [7:0] desc_index;
		logic [1:0] desc_flags;
		logic [7:0] avail_slot;
		logic       notify_device;
		logic       waiter_woken;
		logic [8:0] freed_count;
		logic       last;
	} result_t;

	typedef struct packed {
		logic       pending;
		logic [1:0] flags;
		idx_t       link;
	} desc_word_t;

	typedef struct packed {
		logic       clear;
		logic       rd_en;
		idx_t       rd_addr;
		logic       wr_en;
		idx_t       wr_addr;
		desc_word_t wr_word;
	} mem_req_t;

endpackage

[hdl/vqdm_desc_mem.sv]
// Descriptor table memory: link, flags and pending mark per entry.
// Per-entry valid bits give the init value to entries not written since clear.
// Depends on vqdm_pkg.
module vqdm_desc_mem #(
	parameter int DEPTH = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  vqdm_pkg::mem_req_t  req,
	output vqdm_pkg::desc_word_t rd_word
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	vqdm_pkg::desc_word_t mem_q [DEPTH];
	logic [DEPTH-1:0]     valid_q;
	vqdm_pkg::desc_word_t rd_data_q;
	vqdm_pkg::desc_word_t hit_word_q;
	vqdm_pkg::idx_t       rd_addr_q;
	logic                 rd_valid_q;
	logic                 hit_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr[AW-1:0]] <= req.wr_word;
		end
		if (req.rd_en) begin
			rd_data_q  <= mem_q[req.rd_addr[AW-1:0]];
			rd_addr_q  <= req.rd_addr;
			hit_word_q <= req.wr_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
			hit_q      <= 1'b0;
		end else begin
			if (req.clear) begin
				valid_q <= '0;
			end else if (req.wr_en) begin
				valid_q[req.wr_addr[AW-1:0]] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_valid_q <= valid_q[req.rd_addr[AW-1:0]];
				hit_q      <= req.wr_en && (req.wr_addr == req.rd_addr);
			end
		end
	end

	always_comb begin
		if (hit_q) begin
			rd_word = hit_word_q;
		end else if (rd_valid_q) begin
			rd_word = rd_data_q;
		end else begin
			rd_word.pending = 1'b0;
			rd_word.flags   = 2'b00;
			rd_word.link    = rd_addr_q - 8'd1;
		end
	end

endmodule

[hdl/vqdm_ctrl.sv]
// Sequencer for the descriptor manager: free list head, counters and chain walks.
// Reads, modifies and writes back the descriptor table one entry per cycle.
// Depends on vqdm_pkg.
module vqdm_ctrl #(
	parameter int DEPTH = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  vqdm_pkg::cmd_t       cmd,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [3:0]           cfg_data,
	output vqdm_pkg::mem_req_t   mem_req,
	input  vqdm_pkg::desc_word_t rd_word,
	output logic                 result_valid,
	output vqdm_pkg::result_t    result
);

	localparam int CLOG   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int MAX_LG = ((1 << CLOG) == DEPTH) ? CLOG : CLOG - 1;

	vqdm_pkg::state_t  state_q, state_d;
	logic [3:0]        qlg_q;
	vqdm_pkg::idx_t    free_head_q, free_head_d;
	logic [8:0]        free_total_q, free_total_d;
	logic [15:0]       avail_q, avail_d;
	vqdm_pkg::idx_t    cur_q, cur_d;
	vqdm_pkg::idx_t    head_q, head_d;
	vqdm_pkg::idx_t    slot_q, slot_d;
	logic [1:0]        k_q, k_d;
	logic              has_data_q, has_data_d;
	logic              is_write_q, is_write_d;
	logic              ntf_q, ntf_d;
	logic              woken_q, woken_d;
	logic [8:0]        cnt_q, cnt_d;
	vqdm_pkg::result_t res_q, res_d;
	logic              res_valid_q, res_valid_d;

	logic [3:0]     lg_c;
	logic [8:0]     n;
	vqdm_pkg::idx_t mask;
	vqdm_pkg::idx_t next_idx;
	logic [8:0]     need;
	logic [1:0]     flags_k;
	logic           sub_last;
	logic [8:0]     cnt_new;
	logic           wake_now;

	always_comb begin
		if (qlg_q == 4'd0) begin
			lg_c = 4'd1;
		end else if (qlg_q > 4'd8) begin
			lg_c = 4'd8;
		end else begin
			lg_c = qlg_q;
		end
		if (lg_c > 4'(MAX_LG)) begin
			lg_c = 4'(MAX_LG);
		end
		n    = 9'd1 << lg_c;
		mask = 8'(n - 9'd1);
	end

	assign busy      = (state_q != vqdm_pkg::ST_IDLE);
	assign cfg_ready = (state_q == vqdm_pkg::ST_IDLE);
	assign next_idx  = rd_word.link & mask;
	assign need      = cmd.has_data ? 9'd3 : 9'd2;
	assign cnt_new   = cnt_q + 9'd1;
	assign wake_now  = (cnt_q == 9'd0) ? rd_word.pending : woken_q;
	assign sub_last  = (k_q == 2'd2) || ((k_q == 2'd1) && !has_data_q);

	always_comb begin
		case (k_q)
			2'd0: flags_k = vqdm_pkg::FLAG_NEXT;
			2'd1: begin
				if (!has_data_q) begin
					flags_k = vqdm_pkg::FLAG_WRITE;
				end else if (is_write_q) begin
					flags_k = vqdm_pkg::FLAG_NEXT;
				end else begin
					flags_k = vqdm_pkg::FLAG_WRITE | vqdm_pkg::FLAG_NEXT;
				end
			end
			default: flags_k = vqdm_pkg::FLAG_WRITE;
		endcase
	end

	always_comb begin
		state_d      = state_q;
		free_head_d  = free_head_q;
		free_total_d = free_total_q;
		avail_d      = avail_q;
		cur_d        = cur_q;
		head_d       = head_q;
		slot_d       = slot_q;
		k_d          = k_q;
		has_data_d   = has_data_q;
		is_write_d   = is_write_q;
		ntf_d        = ntf_q;
		woken_d      = woken_q;
		cnt_d        = cnt_q;
		res_d        = '0;
		res_valid_d  = 1'b0;
		mem_req      = '0;
		case (state_q)
			vqdm_pkg::ST_IDLE: begin
				if (start) begin
					case (cmd.operation)
						vqdm_pkg::OP_INIT: begin
							mem_req.clear = 1'b1;
							free_head_d   = mask;
							free_total_d  = n;
							avail_d       = 16'd0;
							res_valid_d   = 1'b1;
							res_d.last    = 1'b1;
						end
						vqdm_pkg::OP_SUBMIT: begin
							if (free_total_q < need) begin
								res_valid_d  = 1'b1;
								res_d.status = 1'b1;
								res_d.last   = 1'b1;
							end else begin
								mem_req.rd_en   = 1'b1;
								mem_req.rd_addr = free_head_q & mask;
								cur_d        = free_head_q & mask;
								k_d          = 2'd0;
								has_data_d   = cmd.has_data;
								is_write_d   = cmd.is_write;
								ntf_d        = !cmd.notify_suppressed;
								slot_d       = avail_q[7:0] & mask;
								free_total_d = free_total_q - need;
								avail_d      = avail_q + 16'd1;
								state_d      = vqdm_pkg::ST_SUB;
							end
						end
						vqdm_pkg::OP_COMPLETE: begin
							mem_req.rd_en   = 1'b1;
							mem_req.rd_addr = cmd.used_id & mask;
							cur_d   = cmd.used_id & mask;
							head_d  = cmd.used_id & mask;
							cnt_d   = 9'd0;
							state_d = vqdm_pkg::ST_CPL;
						end
						default: ;
					endcase
				end
			end
			vqdm_pkg::ST_SUB: begin
				mem_req.wr_en           = 1'b1;
				mem_req.wr_addr         = cur_q;
				mem_req.wr_word.pending = (k_q == 2'd0) ? 1'b1 : rd_word.pending;
				mem_req.wr_word.flags   = flags_k;
				mem_req.wr_word.link    = rd_word.link;
				res_valid_d         = 1'b1;
				res_d.desc_index    = cur_q;
				res_d.desc_flags    = flags_k;
				res_d.avail_slot    = slot_q;
				res_d.notify_device = ntf_q;
				res_d.last          = sub_last;
				if (sub_last) begin
					free_head_d = rd_word.link;
					state_d     = vqdm_pkg::ST_IDLE;
				end else begin
					mem_req.rd_en   = 1'b1;
					mem_req.rd_addr = next_idx;
					cur_d = next_idx;
					k_d   = k_q + 2'd1;
				end
			end
			vqdm_pkg::ST_CPL: begin
				mem_req.wr_en           = 1'b1;
				mem_req.wr_addr         = cur_q;
				mem_req.wr_word.pending = (cnt_q == 9'd0) ? 1'b0 : rd_word.pending;
				mem_req.wr_word.flags   = rd_word.flags;
				mem_req.wr_word.link    = free_head_q;
				woken_d     = wake_now;
				free_head_d = cur_q;
				if (free_total_q < n) begin
					free_total_d = free_total_q + 9'd1;
				end
				cnt_d = cnt_new;
				if (((rd_word.flags & vqdm_pkg::FLAG_NEXT) != 2'b00) && (cnt_new < n)) begin
					mem_req.rd_en   = 1'b1;
					mem_req.rd_addr = next_idx;
					cur_d = next_idx;
				end else begin
					res_valid_d        = 1'b1;
					res_d.desc_index   = head_q;
					res_d.waiter_woken = wake_now;
					res_d.freed_count  = cnt_new;
					res_d.last         = 1'b1;
					state_d            = vqdm_pkg::ST_IDLE;
				end
			end
			default: state_d = vqdm_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= vqdm_pkg::ST_IDLE;
			qlg_q        <= 4'd8;
			free_head_q  <= 8'((1 << MAX_LG) - 1);
			free_total_q <= 9'(1 << MAX_LG);
			avail_q      <= 16'd0;
			res_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			free_head_q  <= free_head_d;
			free_total_q <= free_total_d;
			avail_q      <= avail_d;
			res_valid_q  <= res_valid_d;
			if (cfg_valid && cfg_ready) begin
				qlg_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		cur_q      <= cur_d;
		head_q     <= head_d;
		slot_q     <= slot_d;
		k_q        <= k_d;
		has_data_q <= has_data_d;
		is_write_q <= is_write_d;
		ntf_q      <= ntf_d;
		woken_q    <= woken_d;
		cnt_q      <= cnt_d;
		res_q      <= res_d;
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

[hdl/virtqueue_descriptor_manager_top.sv]
// Top level of the split virtqueue descriptor manager.
// Instantiates vqdm_ctrl and vqdm_desc_mem; depends on vqdm_pkg.
//
// An item is taken when start is high and busy is low. Init, a refused submit and
// operation 3 keep busy low. An accepted submit holds busy while it visits its
// 2 or 3 chain descriptors, and a completion while it walks its chain (up to the
// queue size), one descriptor per step, because each step is a read, modify and
// write of the single descriptor table memory. Results are registered, each
// strobed on result_valid for one cycle, back to back within an item; the
// receiver cannot stall them. Init and reset clear the table at once through
// per-entry valid bits, with no clearing pass.
module virtqueue_descriptor_manager_top #(
	parameter int QUEUE_DEPTH = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  vqdm_pkg::cmd_t    cmd,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [3:0]        cfg_data,
	output logic              result_valid,
	output vqdm_pkg::result_t result
);

	localparam int DEPTH = (QUEUE_DEPTH < 256) ? QUEUE_DEPTH : 256;

	vqdm_pkg::mem_req_t   mem_req;
	vqdm_pkg::desc_word_t rd_word;

	vqdm_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.mem_req      (mem_req),
		.rd_word      (rd_word),
		.result_valid (result_valid),
		.result       (result)
	);

	vqdm_desc_mem #(
		.DEPTH(DEPTH)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mem_req),
		.rd_word (rd_word)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.wr_en |-> busy)
		else $error("Table written while idle.");

	assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.clear |-> !busy && !mem_req.wr_en && !mem_req.rd_en)
		else $error("Table clear overlaps an access.");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last |=> result_valid)
		else $error("Gap inside a chain of results.");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status || (result.freed_count != 9'd0)) |-> result.last)
		else $error("Single-result item without last.");

endmodule

[tb/virtqueue_descriptor_manager_top_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for virtqueue_descriptor_manager_top: a directed table, then random
// phases of submits, completions, inits and noise under several queue sizes, checked against
// a built-in model of the descriptor table. Depends on vqdm_pkg and the top level only.
module virtqueue_descriptor_manager_top_tb;

	localparam int QUEUE_DEPTH = 256;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASE_ITEMS = 14;
	localparam int NUM_PHASES = 8;
	localparam logic [1:0] OP_NOP = 2'd3;
	localparam logic [8:0] END_MARK = 9'h1FF;

	typedef struct {
		bit                is_cfg;
		logic [3:0]        cfg_value;
		vqdm_pkg::cmd_t    c;
		bit                typed;
		vqdm_pkg::result_t typed_res;
	} row_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	vqdm_pkg::cmd_t    cmd;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [3:0]        cfg_data;
	logic              result_valid;
	vqdm_pkg::result_t result;

	logic [8:0] link_table [QUEUE_DEPTH];
	logic [1:0] flag_table [QUEUE_DEPTH];
	bit         pending_table [QUEUE_DEPTH];
	logic [8:0] free_head;
	logic [8:0] free_count;
	logic [15:0] avail_count;
	logic [15:0] used_count;
	logic [3:0] size_log2;

	vqdm_pkg::result_t chain_results [$];
	vqdm_pkg::result_t expected_results [$];
	row_t              directed_rows [$];

	int mismatches = 0;
	int items_sent = 0;
	int results_seen = 0;
	int refusals = 0;
	int wakes = 0;
	int longest_walk = 0;
	int size_writes = 0;
	int stall_cycles = 0;
	bit idle_on = 1'b1;

	virtqueue_descriptor_manager_top #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.result_valid(result_valid),
		.result(result)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic int unsigned queue_size();
		int unsigned lg;
		int unsigned n;
		lg = size_log2;
		if (lg < 1) lg = 1;
		if (lg > 8) lg = 8;
		n = 1 << lg;
		while (n > QUEUE_DEPTH && n > 2) n = n >> 1;
		return n;
	endfunction

	function automatic void init_descriptors();
		int unsigned n;
		n = queue_size();
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			link_table[i] = (i == 0) ? END_MARK : 9'(i - 1);
			flag_table[i] = '0;
			pending_table[i] = 1'b0;
		end
		free_head = 9'(n - 1);
		free_count = 9'(n);
		avail_count = '0;
		used_count = '0;
	endfunction

	// Fills chain_results with the results one command causes and updates the descriptor state.
	function automatic void model_command(vqdm_pkg::cmd_t c);
		int unsigned n;
		int unsigned need;
		int unsigned walked;
		logic [8:0] mask;
		logic [8:0] cur;
		logic [8:0] d;
		logic [8:0] head;
		logic [1:0] fl [3];
		vqdm_pkg::result_t r;
		n = queue_size();
		mask = 9'(n - 1);
		chain_results.delete();
		r = '0;
		if (c.operation == vqdm_pkg::OP_INIT) begin
			init_descriptors();
			r.last = 1'b1;
			chain_results.push_back(r);
		end else if (c.operation == vqdm_pkg::OP_SUBMIT) begin
			need = 2 + c.has_data;
			if (free_count < need) begin
				r.status = 1'b1;
				r.last = 1'b1;
				chain_results.push_back(r);
				return;
			end
			fl[0] = vqdm_pkg::FLAG_NEXT;
			fl[2] = vqdm_pkg::FLAG_WRITE;
			if (c.has_data) fl[1] = c.is_write ? vqdm_pkg::FLAG_NEXT :
				(vqdm_pkg::FLAG_WRITE | vqdm_pkg::FLAG_NEXT);
			else fl[1] = vqdm_pkg::FLAG_WRITE;
			cur = free_head;
			head = cur & mask;
			for (int k = 0; k < need; k++) begin
				d = cur & mask;
				flag_table[d] = fl[k];
				cur = link_table[d];
				r.desc_index = d[7:0];
				r.desc_flags = fl[k];
				r.avail_slot = 8'(avail_count & 16'(mask));
				r.notify_device = !c.notify_suppressed;
				r.last = (k + 1 == need);
				chain_results.push_back(r);
			end
			free_head = cur;
			free_count = free_count - 9'(need);
			pending_table[head] = 1'b1;
			avail_count = avail_count + 16'd1;
		end else if (c.operation == vqdm_pkg::OP_COMPLETE) begin
			cur = {1'b0, c.used_id} & mask;
			head = cur;
			r.waiter_woken = pending_table[cur];
			pending_table[cur] = 1'b0;
			used_count = used_count + 16'd1;
			walked = 0;
			do begin
				d = cur & mask;
				cur = link_table[d];
				link_table[d] = free_head;
				free_head = d;
				if (free_count < n) free_count = free_count + 9'd1;
				walked++;
			end while (flag_table[d][0] && walked < n);
			r.desc_index = head[7:0];
			r.freed_count = 9'(walked);
			r.last = 1'b1;
			chain_results.push_back(r);
		end
	endfunction

	task automatic check_result(vqdm_pkg::result_t exp, vqdm_pkg::result_t act);
		if (act.status !== exp.status) begin
			$error("status expected %0d got %0d", exp.status, act.status);
			mismatches++;
		end
		if (act.desc_index !== exp.desc_index) begin
			$error("desc_index expected %0d got %0d", exp.desc_index, act.desc_index);
			mismatches++;
		end
		if (act.desc_flags !== exp.desc_flags) begin
			$error("desc_flags expected %0d got %0d", exp.desc_flags, act.desc_flags);
			mismatches++;
		end
		if (act.avail_slot !== exp.avail_slot) begin
			$error("avail_slot expected %0d got %0d", exp.avail_slot, act.avail_slot);
			mismatches++;
		end
		if (act.notify_device !== exp.notify_device) begin
			$error("notify_device expected %0d got %0d", exp.notify_device, act.notify_device);
			mismatches++;
		end
		if (act.waiter_woken !== exp.waiter_woken) begin
			$error("waiter_woken expected %0d got %0d", exp.waiter_woken, act.waiter_woken);
			mismatches++;
		end
		if (act.freed_count !== exp.freed_count) begin
			$error("freed_count expected %0d got %0d", exp.freed_count, act.freed_count);
			mismatches++;
		end
		if (act.last !== exp.last) begin
			$error("last expected %0d got %0d", exp.last, act.last);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			results_seen++;
			if (result.status) refusals++;
			if (result.waiter_woken) wakes++;
			if (result.freed_count > longest_walk) longest_walk = result.freed_count;
			if (expected_results.size() == 0) begin
				$error("result arrived with nothing expected: %p", result);
				mismatches++;
			end else begin
				check_result(expected_results.pop_front(), result);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || result_valid || (cfg_valid && cfg_ready)) stall_cycles = 0;
			else stall_cycles++;
			if (stall_cycles == STALL_LIMIT) begin
				$display("Timed out with %0d results still expected.", expected_results.size());
				$display("FAIL");
				$finish;
			end
		end
	end

	function automatic vqdm_pkg::cmd_t make_cmd(logic [1:0] op, bit hd, bit iw, bit ns,
			logic [7:0] id);
		vqdm_pkg::cmd_t c;
		c.operation = op;
		c.has_data = hd;
		c.is_write = iw;
		c.notify_suppressed = ns;
		c.used_id = id;
		return c;
	endfunction

	function automatic row_t cmd_row(logic [1:0] op, bit hd, bit iw, bit ns, logic [7:0] id);
		row_t r;
		r.is_cfg = 1'b0;
		r.cfg_value = '0;
		r.c = make_cmd(op, hd, iw, ns, id);
		r.typed = 1'b0;
		r.typed_res = '0;
		return r;
	endfunction

	function automatic row_t with_result(row_t r, bit st, logic [7:0] idx, bit woken,
			logic [8:0] freed);
		r.typed = 1'b1;
		r.typed_res = '0;
		r.typed_res.status = st;
		r.typed_res.desc_index = idx;
		r.typed_res.waiter_woken = woken;
		r.typed_res.freed_count = freed;
		r.typed_res.last = 1'b1;
		return r;
	endfunction

	function automatic row_t cfg_row(logic [3:0] v);
		row_t r;
		r = cmd_row(OP_NOP, 0, 0, 0, 0);
		r.is_cfg = 1'b1;
		r.cfg_value = v;
		return r;
	endfunction

	task automatic send_command(vqdm_pkg::cmd_t c, bit typed, vqdm_pkg::result_t typed_res);
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy);
		model_command(c);
		if (typed) expected_results.push_back(typed_res);
		else foreach (chain_results[i]) expected_results.push_back(chain_results[i]);
		if (c.operation != OP_NOP) items_sent++;
		@(negedge clk);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
	endtask

	task automatic wait_for_drain();
		start <= 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_size(logic [3:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		size_log2 = v;
		size_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_command(output vqdm_pkg::cmd_t c);
		int unsigned n;
		int heads [$];
		logic [7:0] mask;
		c = vqdm_pkg::cmd_t'($urandom);
		if ($urandom_range(0, 99) < 15) return;
		n = queue_size();
		mask = 8'(n - 1);
		for (int i = 0; i < n; i++) if (pending_table[i]) heads.push_back(i);
		if (heads.size() != 0 && $urandom_range(0, 1) == 0) begin
			c.operation = vqdm_pkg::OP_COMPLETE;
			c.used_id = 8'(heads[$urandom_range(0, heads.size() - 1)]) |
				(8'($urandom) & ~mask);
		end else begin
			c.operation = vqdm_pkg::OP_SUBMIT;
		end
	endtask

	initial begin
		logic [3:0] phase_sizes [NUM_PHASES];
		vqdm_pkg::cmd_t c;
		int phase_count;
		phase_sizes = '{4'd3, 4'd1, 4'd8, 4'd2, 4'd0, 4'd15, 4'd5, 4'd4};
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		size_log2 = 4'd8;
		init_descriptors();

		directed_rows.push_back(with_result(cmd_row(vqdm_pkg::OP_INIT, 0, 0, 0, 0),
			0, 0, 0, 0));
		directed_rows.push_back(cmd_row(vqdm_pkg::OP_SUBMIT, 0, 0, 0, 0));
		directed_rows.push_back(cmd_row(vqdm_pkg::OP_SUBMIT, 1, 1, 1, 0));
		directed_rows.push_back(cmd_row(vqdm_pkg::OP_SUBMIT, 1, 0, 0, 0));
		directed_rows.push_back(with_result(cmd_row(vqdm_pkg::OP_COMPLETE, 0, 0, 0, 253),
			0, 253, 1, 3));
		directed_rows.push_back(cmd_row(vqdm_pkg::OP_COMPLETE, 0, 0, 0, 253));
		directed_rows.push_back(with_result(cmd_row(vqdm_pkg::OP_COMPLETE, 0, 0, 0, 0),
			0, 0, 0, 1));
		directed_rows.push_back(cmd_row(OP_NOP, 1, 1, 1, 8'hFF));
		directed_rows.push_back(with_result(cmd_row(vqdm_pkg::OP_COMPLETE, 1, 1, 1, 255),
			0, 255, 1, 2));
		directed_rows.push_back(cmd_row(vqdm_pkg::OP_SUBMIT, 0, 1, 1, 8'hFF));
		directed_rows.push_back(with_result(cmd_row(vqdm_pkg::OP_INIT, 1, 1, 1, 8'hFF),
			0, 0, 0, 0));
		directed_rows.push_back(cfg_row(4'd0));
		directed_rows.push_back(with_result(cmd_row(vqdm_pkg::OP_INIT, 0, 0, 0, 0),
			0, 0, 0, 0));
		directed_rows.push_back(with_result(cmd_row(vqdm_pkg::OP_SUBMIT, 1, 0, 0, 0),
			1, 0, 0, 0));
		directed_rows.push_back(cmd_row(vqdm_pkg::OP_SUBMIT, 0, 0, 0, 255));
		directed_rows.push_back(with_result(cmd_row(vqdm_pkg::OP_SUBMIT, 0, 1, 1, 0),
			1, 0, 0, 0));
		directed_rows.push_back(with_result(cmd_row(vqdm_pkg::OP_COMPLETE, 0, 0, 0, 255),
			0, 1, 1, 2));
		directed_rows.push_back(cfg_row(4'd15));
		directed_rows.push_back(cmd_row(vqdm_pkg::OP_SUBMIT, 1, 1, 0, 0));
		directed_rows.push_back(cmd_row(vqdm_pkg::OP_COMPLETE, 0, 0, 0, 0));
		directed_rows.push_back(with_result(cmd_row(vqdm_pkg::OP_INIT, 0, 0, 0, 0),
			0, 0, 0, 0));

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg) begin
				wait_for_drain();
				write_size(directed_rows[i].cfg_value);
			end else begin
				send_command(directed_rows[i].c, directed_rows[i].typed,
					directed_rows[i].typed_res);
			end
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_for_drain();
			write_size(phase_sizes[p]);
			idle_on = (p != NUM_PHASES - 1) && ($urandom_range(0, 2) != 0);
			phase_count = 0;
			if ($urandom_range(0, 3) != 0) begin
				send_command(make_cmd(vqdm_pkg::OP_INIT, 0, 0, 0, 0), 1'b0, '0);
				phase_count++;
			end
			while (phase_count < PHASE_ITEMS) begin
				random_command(c);
				send_command(c, 1'b0, '0);
				if (c.operation != OP_NOP) phase_count++;
			end
		end

		start <= 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		$display("Covered %0d items and %0d results over %0d queue size writes.",
			items_sent, results_seen, size_writes);
		$display("Saw %0d refused submits, %0d wakes, longest completion walk %0d.",
			refusals, wakes, longest_walk);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
